### design/lrht_pkg.sv
// Package for the lock record hash table: widths, codes and hash helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lrht_pkg;
  localparam int TABLE_SIZE_DEF = 16;
  localparam int NUM_SLOTS_DEF  = 4;
  localparam int HashMul        = 10;
  localparam logic [4:0] COUNT_MAX = 5'd31;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_QUERY   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_QUERY3  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_HELD     = 3'd3,
    ST_NOT_HELD = 3'd4,
    ST_RELEASED = 3'd5,
    ST_NONE     = 3'd6
  } status_t;

  typedef struct packed {
    logic [31:0] tuple;
    logic [3:0]  tbl;
    logic        mode;
    logic [15:0] row;
  } entry_t;

  // tuple mod 10 by reciprocal multiply: q = (v * 0xCCCCCCCD) >> 35
  function automatic logic [3:0] mod10(input logic [31:0] v);
    logic [63:0] p;
    logic [31:0] q;
    logic [31:0] r;
    p = {32'd0, v} * 64'h00000000CCCCCCCD;
    q = {3'd0, p[63:35]};
    r = v - ((q << 3) + (q << 1));
    return r[3:0];
  endfunction
endpackage
`default_nettype wire

### design/lock_record_hash_table_unit.sv
// Lock record hash table top: rotating ring of entry cells per slot.
// Depends on lrht_pkg and lrht_cell.
// Insert/query: S_HASH, S_PROBE (skipped for tuple zero), S_OUT, output register;
// in S_PROBE the slot ring rotates once, one entry per cycle, past the slot head.
// Release: ring rotates only while the output register is free; the final beat
// is emitted from S_RFIN. One item at a time: the next accept waits for S_IDLE
// and a free output register.
// Reset: synchronous rst_n clears all entries and counts at once.
`timescale 1ns / 1ps
`default_nettype none
module lock_record_hash_table_unit #(
  parameter int TABLE_SIZE = lrht_pkg::TABLE_SIZE_DEF,
  parameter int NUM_SLOTS  = lrht_pkg::NUM_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // action[1:0] slot[3:2] table_number[7:4] tuple_key[39:8] mode[40] record_row[56:41]
  input  wire logic [63:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[2:0] out_table[6:3] out_row[22:7] held_count[27:23]
  output logic [31:0]      out_tdata,
  output logic             out_tlast
);
  import lrht_pkg::*;
  localparam int N  = NUM_SLOTS * TABLE_SIZE;
  localparam int PW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_HASH, S_PROBE, S_OUT, S_REL, S_RFIN} state_t;
  state_t state_r;

  entry_t       ent [N];
  entry_t       heads [NUM_SLOTS];
  logic [N-1:0] wr_en;
  logic [N-1:0] clr_en;
  logic [N-1:0] sh_en;
  entry_t       wr_data;
  entry_t       head;

  logic [1:0]    act_r;
  logic [SW-1:0] slot_r;
  logic [3:0]    tb_r;
  logic [31:0]   tu_r;
  logic          md_r;
  logic [15:0]   row_r;
  logic [3:0]    m10_r;
  logic [PW-1:0] home_r;
  logic [PW-1:0] k_r;
  logic          hi_v_r;
  logic          lo_v_r;
  logic [PW-1:0] hi_pos_r;
  logic [PW-1:0] lo_pos_r;
  status_t       hi_st_r;
  status_t       lo_st_r;
  logic [4:0]    cnt_r [NUM_SLOTS];
  logic          any_r;
  logic [3:0]    pend_tb_r;
  logic [15:0]   pend_row_r;
  logic [2:0]    o_st_r;
  logic [3:0]    o_tb_r;
  logic [15:0]   o_row_r;
  logic [4:0]    o_cnt_r;
  logic          o_last_r;
  logic          o_v_r;

  logic [PW-1:0] home_lut [16][10];
  logic [SW-1:0] slot_lut [4];
  logic          is_ins, can_go, rot_en, clr_slot, wr_ent, stop_here, emit, e_last;
  logic [PW-1:0] win_pos;
  status_t       stop_st, miss_st, fin_st, e_st;
  logic [4:0]    cnt_cur, cnt_inc, e_cnt;
  logic [3:0]    e_tb;
  logic [15:0]   e_row;

  // cells; each step the slot ring shifts toward its head cell
  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int SL = g / TABLE_SIZE;
    localparam int IX = g % TABLE_SIZE;
    localparam int NX = SL * TABLE_SIZE + ((IX + 1) % TABLE_SIZE);
    assign sh_en[g]  = rot_en && (slot_r == SW'(SL));
    assign clr_en[g] = clr_slot && (slot_r == SW'(SL));
    assign wr_en[g]  = wr_ent && (slot_r == SW'(SL)) && (win_pos == PW'(IX));
    lrht_cell u_cell (
      .clk(clk), .rst_n(rst_n), .wr_en(wr_en[g]), .clr_en(clr_en[g]),
      .wr_data(wr_data), .shift_in(ent[NX]), .shift_en(sh_en[g]),
      .entry(ent[g])
    );
  end

  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_head
    assign heads[s] = ent[s * TABLE_SIZE];
  end

  // home entry per (table, tuple mod 10)
  for (genvar a = 0; a < 16; a++) begin : g_ht
    for (genvar b = 0; b < 10; b++) begin : g_hm
      assign home_lut[a][b] = PW'(((a * HashMul) % TABLE_SIZE + b) % TABLE_SIZE);
    end
  end

  for (genvar a = 0; a < 4; a++) begin : g_sl
    assign slot_lut[a] = SW'(a % NUM_SLOTS);
  end

  assign head    = heads[slot_r];
  assign wr_data = '{tuple: tu_r, tbl: tb_r, mode: md_r, row: row_r};
  assign is_ins  = (act_r == ACT_INSERT);
  assign can_go  = !o_v_r || out_tready;
  assign rot_en  = (state_r == S_PROBE) || (state_r == S_REL && can_go);
  assign clr_slot = (state_r == S_RFIN) && can_go;

  always_comb begin
    miss_st   = is_ins ? ST_FULL : ST_NOT_HELD;
    stop_here = 1'b0;
    stop_st   = miss_st;
    if (head.tuple == '0) begin
      stop_here = 1'b1;
      stop_st   = is_ins ? ST_INSERTED : ST_NOT_HELD;
    end else if (head.tbl == tb_r && head.tuple == tu_r &&
                 (is_ins || head.mode == md_r)) begin
      stop_here = 1'b1;
      stop_st   = is_ins ? ST_PRESENT : ST_HELD;
    end
  end

  // first stop at or after home wins, else first stop before home
  assign fin_st  = hi_v_r ? hi_st_r : (lo_v_r ? lo_st_r : miss_st);
  assign win_pos = hi_v_r ? hi_pos_r : lo_pos_r;
  assign wr_ent  = (state_r == S_OUT) && can_go && (fin_st == ST_INSERTED);
  assign cnt_cur = cnt_r[slot_r];
  assign cnt_inc = (fin_st == ST_INSERTED && cnt_cur != COUNT_MAX) ?
                   cnt_cur + 5'd1 : cnt_cur;

  always_comb begin
    emit   = 1'b0;
    e_st   = fin_st;
    e_tb   = '0;
    e_row  = '0;
    e_cnt  = '0;
    e_last = 1'b1;
    case (state_r)
      S_OUT: begin
        emit  = can_go;
        e_cnt = cnt_inc;
      end
      S_REL: begin
        // previous held entry goes out once a later one shows it is not last
        emit   = can_go && (head.tuple != '0) && any_r;
        e_st   = ST_RELEASED;
        e_tb   = pend_tb_r;
        e_row  = pend_row_r;
        e_last = 1'b0;
      end
      S_RFIN: begin
        emit  = can_go;
        e_st  = any_r ? ST_RELEASED : ST_NONE;
        e_tb  = any_r ? pend_tb_r : 4'd0;
        e_row = any_r ? pend_row_r : 16'd0;
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE) && !o_v_r;
  assign out_tvalid = o_v_r;
  assign out_tdata  = {4'd0, o_cnt_r, o_row_r, o_tb_r, o_st_r};
  assign out_tlast  = o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      o_v_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) cnt_r[i] <= '0;
    end else begin
      if (emit) begin
        o_v_r <= 1'b1;
        o_st_r <= e_st;
        o_tb_r <= e_tb;
        o_row_r <= e_row;
        o_cnt_r <= e_cnt;
        o_last_r <= e_last;
      end else if (out_tready) o_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            act_r <= in_tdata[1:0];
            slot_r <= slot_lut[in_tdata[3:2]];
            tb_r <= in_tdata[7:4];
            tu_r <= in_tdata[39:8];
            md_r <= in_tdata[40];
            row_r <= in_tdata[56:41];
            m10_r <= mod10(in_tdata[39:8]);
            k_r <= '0;
            hi_v_r <= 1'b0;
            lo_v_r <= 1'b0;
            any_r <= 1'b0;
            state_r <= (in_tdata[1:0] == ACT_RELEASE) ? S_REL : S_HASH;
          end
        end
        S_HASH: begin
          home_r <= home_lut[tb_r][m10_r];
          state_r <= (tu_r == '0) ? S_OUT : S_PROBE;
        end
        S_PROBE: begin
          if (stop_here) begin
            if (k_r >= home_r) begin
              if (!hi_v_r) begin
                hi_v_r <= 1'b1;
                hi_pos_r <= k_r;
                hi_st_r <= stop_st;
              end
            end else if (!lo_v_r) begin
              lo_v_r <= 1'b1;
              lo_pos_r <= k_r;
              lo_st_r <= stop_st;
            end
          end
          if (k_r == PW'(TABLE_SIZE - 1)) state_r <= S_OUT;
          else k_r <= k_r + 1'b1;
        end
        S_OUT: begin
          if (can_go) begin
            cnt_r[slot_r] <= cnt_inc;
            state_r <= S_IDLE;
          end
        end
        S_REL: begin
          if (can_go) begin
            if (head.tuple != '0) begin
              any_r <= 1'b1;
              pend_tb_r <= head.tbl;
              pend_row_r <= head.row;
            end
            if (k_r == PW'(TABLE_SIZE - 1)) state_r <= S_RFIN;
            else k_r <= k_r + 1'b1;
          end
        end
        S_RFIN: begin
          if (can_go) begin
            cnt_r[slot_r] <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast));
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid);
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= ST_NONE);
  a_release_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ST_RELEASED |-> out_tdata[27:23] == 5'd0);
endmodule
`default_nettype wire

### design/lrht_cell.sv
// One lock entry cell of the probe ring; entry storage with shift, write and clear.
// Depends on lrht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lrht_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic              clr_en,
  input  wire lrht_pkg::entry_t  wr_data,
  input  wire lrht_pkg::entry_t  shift_in,
  input  wire logic              shift_en,
  output lrht_pkg::entry_t       entry
);
  import lrht_pkg::*;
  entry_t entry_r, entry_nxt;
  always_comb begin
    entry_nxt = entry_r;
    if (shift_en) entry_nxt = shift_in;
    if (wr_en) entry_nxt = wr_data;
    if (clr_en) entry_nxt = '0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) entry_r <= '0;
    else entry_r <= entry_nxt;
  end
  assign entry = entry_r;
endmodule
`default_nettype wire
